FILE: sv/discrete_pid_controller_defines.svh
// Assertion macros for the discrete PID controller.
// Included by dpc_core, which checks its own sequencing; no other dependencies.
`ifndef DISCRETE_PID_CONTROLLER_DEFINES_SVH
`define DISCRETE_PID_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define DPC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dpc check failed");
`define DPC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) (prop)) \
      else $error("dpc check failed");
`else
`define DPC_ASSERT(name, clk, rst, prop)
`define DPC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

FILE: sv/dpc_pkg.sv
// Shared types and constants of the discrete PID controller.
// No dependencies; imported by every module of the block.
package dpc_pkg;

   localparam int GAIN_W   = 20;
   localparam int SAMPLE_W = 16;
   localparam int PERIOD_W = 16;
   localparam int ERR_W    = 17;
   localparam int DERIV_W  = 18;
   localparam int INTEG_W  = 48;
   localparam int DRIVE_W  = 32;
   localparam int OPA_W    = 21;
   localparam int OPB_W    = 29;
   localparam int PROD_W   = OPA_W + OPB_W;
   localparam int ACC_W    = 50;
   localparam int CSR_AW   = 3;

   // register indexes of the configuration port
   localparam logic [CSR_AW-1:0] CSR_GAIN_P   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_GAIN_I   = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_GAIN_D   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_SETPOINT = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_PERIOD   = 3'd4;

   localparam logic signed [GAIN_W-1:0]   GAIN_P_RST   = 20'sd2560;
   localparam logic signed [GAIN_W-1:0]   GAIN_I_RST   = 20'sd204800;
   localparam logic signed [GAIN_W-1:0]   GAIN_D_RST   = 20'sd256;
   localparam logic signed [SAMPLE_W-1:0] SETPOINT_RST = 16'sd4096;
   localparam logic [PERIOD_W-1:0]        PERIOD_RST   = 16'd262;
   localparam logic signed [ERR_W-1:0]    LAST_ERR_RST = -17'sd8192;

   typedef struct packed {
      logic signed [GAIN_W-1:0]   gain_p;
      logic signed [GAIN_W-1:0]   gain_i;
      logic signed [GAIN_W-1:0]   gain_d;
      logic signed [SAMPLE_W-1:0] setpoint;
      logic [PERIOD_W-1:0]        period;
   } cfg_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      saturated;
   } res_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_ERR   = 9'b000000010,
      ST_INTEG = 9'b000000100,
      ST_IHI   = 9'b000001000,
      ST_ILO   = 9'b000010000,
      ST_PROP  = 9'b000100000,
      ST_DER   = 9'b001000000,
      ST_SUM   = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

endpackage

FILE: sv/dpc_mul.sv
// Shared signed multiplier with a registered product.
// Uses dpc_pkg for operand widths.
module dpc_mul
   import dpc_pkg::*;
(
   input  logic                     clock,
   input  logic signed [OPA_W-1:0]  op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] product
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

FILE: sv/dpc_core.sv
// Sequencer and datapath of the PID step around one shared multiplier.
// Uses dpc_pkg, dpc_mul and the assertion macros.
`include "discrete_pid_controller_defines.svh"
module dpc_core
   import dpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [SAMPLE_W-1:0] in_measured,
   output logic                       res_valid,
   input  logic                       res_ready,
   output res_type                    res
);

   state_type state_ff, state_in;

   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;
   logic signed [ERR_W-1:0]   last_error_ff, last_error_in;
   logic signed [INTEG_W-1:0] integral_ff, integral_in;
   logic                      clip_ff, clip_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   logic signed [OPA_W-1:0]   op_a;
   logic signed [OPB_W-1:0]   op_b;
   logic signed [PROD_W-1:0]  product;
   logic signed [INTEG_W:0]   sum_wide;
   logic                      start;
   logic                      drive_over;

   dpc_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   assign in_ready = (state_ff == ST_IDLE);
   assign start    = in_valid && in_ready;

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_ERR: begin
            op_a = $signed({{(OPA_W-PERIOD_W){1'b0}}, cfg.period});
            op_b = $signed({{(OPB_W-ERR_W){err_ff[ERR_W-1]}}, err_ff});
         end
         ST_IHI: begin
            op_a = $signed({{(OPA_W-GAIN_W){cfg.gain_i[GAIN_W-1]}}, cfg.gain_i});
            op_b = $signed({{(OPB_W-INTEG_W+20){integral_ff[INTEG_W-1]}},
                            integral_ff[INTEG_W-1:20]});
         end
         ST_ILO: begin
            op_a = $signed({{(OPA_W-GAIN_W){cfg.gain_i[GAIN_W-1]}}, cfg.gain_i});
            op_b = $signed({{(OPB_W-20){1'b0}}, integral_ff[19:0]});
         end
         ST_PROP: begin
            op_a = $signed({{(OPA_W-GAIN_W){cfg.gain_p[GAIN_W-1]}}, cfg.gain_p});
            op_b = $signed({{(OPB_W-ERR_W){err_ff[ERR_W-1]}}, err_ff});
         end
         ST_DER: begin
            op_a = $signed({{(OPA_W-GAIN_W){cfg.gain_d[GAIN_W-1]}}, cfg.gain_d});
            op_b = $signed({{(OPB_W-DERIV_W){deriv_ff[DERIV_W-1]}}, deriv_ff});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign sum_wide = $signed({integral_ff[INTEG_W-1], integral_ff})
                   + $signed({{(INTEG_W-32){product[32]}}, product[32:0]});

   assign drive_over = !((&acc_ff[ACC_W-1:DRIVE_W-1]) || !(|acc_ff[ACC_W-1:DRIVE_W-1]));

   always_comb begin
      state_in      = state_ff;
      err_in        = err_ff;
      deriv_in      = deriv_ff;
      last_error_in = last_error_ff;
      integral_in   = integral_ff;
      clip_in       = clip_ff;
      acc_in        = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               err_in   = ERR_W'(cfg.setpoint) - ERR_W'(in_measured);
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            deriv_in = DERIV_W'(err_ff) - DERIV_W'(last_error_ff);
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            // clamp the new integral to 48 bits
            if (sum_wide[INTEG_W] != sum_wide[INTEG_W-1]) begin
               integral_in = sum_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                               : {1'b0, {(INTEG_W-1){1'b1}}};
               clip_in     = 1'b1;
            end else begin
               integral_in = sum_wide[INTEG_W-1:0];
               clip_in     = 1'b0;
            end
            last_error_in = err_ff;
            state_in      = ST_IHI;
         end
         ST_IHI: begin
            state_in = ST_ILO;
         end
         ST_ILO: begin
            acc_in   = ACC_W'(product);
            state_in = ST_PROP;
         end
         ST_PROP: begin
            acc_in   = acc_ff + ACC_W'(product >>> 20);
            state_in = ST_DER;
         end
         ST_DER: begin
            acc_in   = acc_ff + ACC_W'(product >>> 4);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + ACC_W'(product >>> 4);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the output register frees up
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_valid = (state_ff == ST_FIN);

   always_comb begin
      res.saturated = clip_ff || drive_over;
      if (drive_over) begin
         res.drive = acc_ff[ACC_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                     : {1'b0, {(DRIVE_W-1){1'b1}}};
      end else begin
         res.drive = acc_ff[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_error_ff <= LAST_ERR_RST;
         integral_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         last_error_ff <= last_error_in;
         integral_ff   <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      deriv_ff <= deriv_in;
      clip_ff  <= clip_in;
      acc_ff   <= acc_in;
   end

   `DPC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == ST_IDLE)
   `DPC_ASSERT(a_start_err, clock, reset, start |=> state_ff == ST_ERR)
   `DPC_ASSERT(a_last_err, clock, reset, state_ff == ST_INTEG |=> last_error_ff == $past(err_ff))
   `DPC_ASSERT(a_res_hold, clock, reset, res_valid && !res_ready |=> res_valid && $stable(acc_ff))

endmodule

FILE: sv/discrete_pid_controller.sv
// Discrete PID controller: one measured sample in, one saturated Q16.16 drive word out.
// An item is accepted in idle; its result is built in the states ERR, INTEG, IHI, ILO,
// PROP, DER and SUM and leaves FIN for the output register; only then is the next item
// taken. The single 21x29-bit multiplier, used five times per sample (integral step,
// two halves of the integral term, proportional, derivative), sets the pace.
// A finished result waits in the output register, so the next sample can already be
// worked on. Gains, setpoint and period are written on the csr port while idle; the
// user must keep to it; the block has no check. Depends on dpc_pkg and dpc_core.
module discrete_pid_controller
   import dpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] measured
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [31:0] drive
   output logic [0:0]          rsp_tuser,   // [0] saturated
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [GAIN_W-1:0]   csr_wdata
);

   cfg_type cfg_ff;
   res_type res;
   res_type rsp_word_ff;
   logic    rsp_valid_ff;
   logic    res_valid;
   logic    res_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p   <= GAIN_P_RST;
         cfg_ff.gain_i   <= GAIN_I_RST;
         cfg_ff.gain_d   <= GAIN_D_RST;
         cfg_ff.setpoint <= SETPOINT_RST;
         cfg_ff.period   <= PERIOD_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GAIN_P:   cfg_ff.gain_p   <= csr_wdata;
            CSR_GAIN_I:   cfg_ff.gain_i   <= csr_wdata;
            CSR_GAIN_D:   cfg_ff.gain_d   <= csr_wdata;
            CSR_SETPOINT: cfg_ff.setpoint <= csr_wdata[SAMPLE_W-1:0];
            CSR_PERIOD:   cfg_ff.period   <= csr_wdata[PERIOD_W-1:0];
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   dpc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_measured (req_tdata),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // output register: load when empty or when the current word leaves
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_word_ff.drive;
   assign rsp_tuser[0] = rsp_word_ff.saturated;

endmodule
